### hdl/htfp_pkg.sv
// ----------------------------------------------------------------------------
// htfp_pkg
// Shared constants and types for the header/trailer byte frame parser.
// ----------------------------------------------------------------------------
package htfp_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [31:0]      word_t;
  typedef logic [0:0]       entry_t;
  typedef logic [1:0]       lane_t;

  localparam byte_t HDR_BYTE      = 8'hF9;
  localparam byte_t TAIL_BYTE     = 8'hF0;
  localparam word_t SENTINEL_BITS = 32'h4479_C000;

  localparam pos_t POS_HUNT0   = POS_W'(0);
  localparam pos_t POS_HUNT1   = POS_W'(1);
  localparam pos_t POS_X_FIRST = POS_W'(2);
  localparam pos_t POS_Y_LAST  = POS_W'(9);
  localparam pos_t POS_COUNT   = POS_W'(10);
  localparam pos_t POS_TAIL0   = POS_W'(11);
  localparam pos_t POS_TAIL1   = POS_W'(FRAME_BYTES - 1);

  localparam entry_t ENTRY_X = 1'b0;
  localparam entry_t ENTRY_Y = 1'b1;

  function automatic word_t unsentinel(input word_t w);
    return (w == SENTINEL_BITS) ? '0 : w;
  endfunction

endpackage

### hdl/header_trailer_frame_parser.sv
// ----------------------------------------------------------------------------
// header_trailer_frame_parser
// Hunts for two 0xF9 header bytes, collects a 13-byte frame and, when both
// tail bytes are 0xF0, delivers the two offset words and the count byte.
//
//   channel | dir | ports
//   --------+-----+-------------------------------------------------------
//   in      | in  | in_valid, in_stall (out), in_rx_byte
//   out     | out | out_valid, out_stall (in), out_x_offset_bits,
//           |     | out_y_offset_bits, out_frame_counter
//
// A byte is taken per cycle while in_valid is high and in_stall low. The
// offset bytes are merged into a two-entry word memory by read, modify and
// write, with the last write forwarded to the merge stage. Results pass stage
// 2, then the output registers. Reset clears the position and the valid flags
// only. The input stalls only while a result waits and the final byte is due.
// ----------------------------------------------------------------------------
module header_trailer_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x_offset_bits,
  output logic [31:0] out_y_offset_bits,
  output logic [7:0]  out_frame_counter
);

  htfp_pkg::word_t  frame_mem [2];

  htfp_pkg::pos_t   pos_r, pos_nxt;
  logic             in_acc;
  logic             is_rmw, is_fin;
  logic [htfp_pkg::POS_W-1:0] idx;
  htfp_pkg::entry_t rd_addr;

  htfp_pkg::word_t  rd_a_r, rd_b_r;
  logic             s2_rmw_r, s2_fin_r, s2_tail_ok_r;
  htfp_pkg::byte_t  s2_byte_r;
  htfp_pkg::lane_t  s2_lane_r;
  htfp_pkg::entry_t s2_entry_r;

  logic             lw_valid_r;
  htfp_pkg::entry_t lw_entry_r;
  htfp_pkg::word_t  lw_data_r;

  logic             tail0_ok_r;
  htfp_pkg::byte_t  count_r;

  htfp_pkg::word_t  merge_base, merged;

  logic             out_valid_r;
  htfp_pkg::word_t  out_x_r, out_y_r;
  htfp_pkg::byte_t  out_cnt_r;

  assign in_stall = out_valid_r && (pos_r == htfp_pkg::POS_TAIL1);
  assign in_acc   = in_valid && !in_stall;

  assign is_rmw  = (pos_r >= htfp_pkg::POS_X_FIRST) && (pos_r <= htfp_pkg::POS_Y_LAST);
  assign is_fin  = (pos_r == htfp_pkg::POS_TAIL1);
  assign idx     = pos_r - htfp_pkg::POS_X_FIRST;
  assign rd_addr = is_fin ? htfp_pkg::ENTRY_X : htfp_pkg::entry_t'(idx[2]);

  always_comb begin
    pos_nxt = pos_r;
    if (pos_r == htfp_pkg::POS_HUNT0) begin
      if (in_rx_byte == htfp_pkg::HDR_BYTE) begin
        pos_nxt = htfp_pkg::POS_HUNT1;
      end
    end else if (pos_r == htfp_pkg::POS_HUNT1) begin
      pos_nxt = (in_rx_byte == htfp_pkg::HDR_BYTE) ? htfp_pkg::POS_X_FIRST
                                                     : htfp_pkg::POS_HUNT0;
    end else if (pos_r >= htfp_pkg::POS_TAIL1) begin
      pos_nxt = htfp_pkg::POS_HUNT0;
    end else begin
      pos_nxt = pos_r + htfp_pkg::pos_t'(1);
    end
  end

  always_comb begin
    merge_base = (lw_valid_r && (lw_entry_r == s2_entry_r)) ? lw_data_r : rd_a_r;
    merged     = merge_base;
    case (s2_lane_r)
      2'd0:    merged[7:0]   = s2_byte_r;
      2'd1:    merged[15:8]  = s2_byte_r;
      2'd2:    merged[23:16] = s2_byte_r;
      2'd3:    merged[31:24] = s2_byte_r;
      default: merged        = merge_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (is_rmw || is_fin)) begin
      rd_a_r <= frame_mem[rd_addr];
      rd_b_r <= frame_mem[htfp_pkg::ENTRY_Y];
    end
    if (s2_rmw_r) begin
      frame_mem[s2_entry_r] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfp_pkg::POS_HUNT0;
      s2_rmw_r    <= 1'b0;
      s2_fin_r    <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
      s2_rmw_r <= in_acc && is_rmw;
      s2_fin_r <= in_acc && is_fin;
      if (s2_rmw_r) begin
        lw_valid_r <= 1'b1;
      end
      if (s2_fin_r && s2_tail_ok_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_byte_r    <= in_rx_byte;
      s2_lane_r    <= idx[1:0];
      s2_entry_r   <= htfp_pkg::entry_t'(idx[2]);
      s2_tail_ok_r <= tail0_ok_r && (in_rx_byte == htfp_pkg::TAIL_BYTE);
      if (pos_r == htfp_pkg::POS_COUNT) begin
        count_r <= in_rx_byte;
      end
      if (pos_r == htfp_pkg::POS_TAIL0) begin
        tail0_ok_r <= (in_rx_byte == htfp_pkg::TAIL_BYTE);
      end
    end
    if (s2_rmw_r) begin
      lw_entry_r <= s2_entry_r;
      lw_data_r  <= merged;
    end
    if (s2_fin_r && s2_tail_ok_r) begin
      out_x_r   <= htfp_pkg::unsentinel(rd_a_r);
      out_y_r   <= htfp_pkg::unsentinel(rd_b_r);
      out_cnt_r <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x_offset_bits = out_x_r;
  assign out_y_offset_bits = out_y_r;
  assign out_frame_counter = out_cnt_r;

endmodule

### hdl/htfp_checker.sv
// ----------------------------------------------------------------------------
// htfp_checker
// Port-level checks for the header/trailer byte frame parser.
// ----------------------------------------------------------------------------
module htfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x_offset_bits,
  input logic [31:0] out_y_offset_bits,
  input logic [7:0]  out_frame_counter
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_offset_bits) &&
      $stable(out_y_offset_bits) && $stable(out_frame_counter))
    else $error("stalled result changed");

  a_rise_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a final word two cycles earlier");

  a_no_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_offset_bits != htfp_pkg::SENTINEL_BITS) &&
      (out_y_offset_bits != htfp_pkg::SENTINEL_BITS))
    else $error("sentinel word delivered");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind header_trailer_frame_parser htfp_checker u_htfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_x_offset_bits (out_x_offset_bits),
  .out_y_offset_bits (out_y_offset_bits),
  .out_frame_counter (out_frame_counter)
);
